>>> sv/b64e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder package
// Shared types, character constants and the symbol-to-ASCII mapping.
// ----------------------------------------------------------------------------
package b64e_pkg;

    // Depth of the queue between the byte front end and the character back end.
    localparam int QUEUE_DEPTH = 2;

    // Most characters one byte can cause: its own symbols plus the padding.
    localparam int MAX_CHARS = 4;

    // ASCII codes used by the alphabet and the padding.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    // Symbol ranges of the alphabet.
    localparam logic [5:0] SYM_LOWER_START = 6'd26;
    localparam logic [5:0] SYM_DIGIT_START = 6'd52;
    localparam logic [5:0] SYM_PLUS        = 6'd62;

    // Position within a three-byte group.
    typedef enum logic [1:0] {
        PHASE_0 = 2'd0,
        PHASE_1 = 2'd1,
        PHASE_2 = 2'd2
    } phase_t;

    // One queued request: the characters a byte causes, in emit order.
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [1:0]                last_idx;
        logic                      final_req;
    } b64e_req_t;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } b64e_qstat_t;

    // Map a 6-bit symbol to its ASCII character.
    function automatic logic [7:0] sym_to_ascii(input logic [5:0] sym);
        logic [7:0] sx;
        sx = {2'b00, sym};
        if (sym < SYM_LOWER_START)
            return CHAR_UPPER_A + sx;
        else if (sym < SYM_DIGIT_START)
            return CHAR_LOWER_A + sx - {2'b00, SYM_LOWER_START};
        else if (sym < SYM_PLUS)
            return CHAR_DIGIT_0 + sx - {2'b00, SYM_DIGIT_START};
        else if (sym == SYM_PLUS)
            return CHAR_PLUS;
        else
            return CHAR_SLASH;
    endfunction

endpackage

>>> sv/b64e_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts bytes, tracks the group phase and leftover bits, and builds one
// request holding every character the byte causes.
// ----------------------------------------------------------------------------
module b64e_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  final_byte,
    input  b64e_pkg::b64e_qstat_t qstat,
    output logic                  push,
    output b64e_pkg::b64e_req_t   req
);

    b64e_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       leftover_reg, leftover_next;
    logic             accept;

    // A byte is taken whenever the queue has room.
    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept;

    // Classify the byte by the group phase and lay out its characters.
    always_comb
    begin
        req           = '0;
        phase_next    = phase_reg;
        leftover_next = leftover_reg;
        req.final_req = final_byte;
        unique case (phase_reg)
            b64e_pkg::PHASE_1:
            begin
                req.chars[0] = b64e_pkg::sym_to_ascii({leftover_reg[1:0], data_byte[7:4]});
                if (final_byte)
                begin
                    req.chars[1] = b64e_pkg::sym_to_ascii({data_byte[3:0], 2'b00});
                    req.chars[2] = b64e_pkg::CHAR_PAD;
                    req.last_idx = 2'd2;
                    phase_next    = b64e_pkg::PHASE_0;
                    leftover_next = '0;
                end
                else
                begin
                    req.last_idx  = 2'd0;
                    phase_next    = b64e_pkg::PHASE_2;
                    leftover_next = data_byte[3:0];
                end
            end
            b64e_pkg::PHASE_2:
            begin
                req.chars[0]  = b64e_pkg::sym_to_ascii({leftover_reg, data_byte[7:6]});
                req.chars[1]  = b64e_pkg::sym_to_ascii(data_byte[5:0]);
                req.last_idx  = 2'd1;
                phase_next    = b64e_pkg::PHASE_0;
                leftover_next = '0;
            end
            default:
            begin
                // Phase zero, and the unused code treated the same way.
                req.chars[0] = b64e_pkg::sym_to_ascii(data_byte[7:2]);
                if (final_byte)
                begin
                    req.chars[1]  = b64e_pkg::sym_to_ascii({data_byte[1:0], 4'b0000});
                    req.chars[2]  = b64e_pkg::CHAR_PAD;
                    req.chars[3]  = b64e_pkg::CHAR_PAD;
                    req.last_idx  = 2'd3;
                    phase_next    = b64e_pkg::PHASE_0;
                    leftover_next = '0;
                end
                else
                begin
                    req.last_idx  = 2'd0;
                    phase_next    = b64e_pkg::PHASE_1;
                    leftover_next = {2'b00, data_byte[1:0]};
                end
            end
        endcase
    end

    // Group state advances only on an accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= b64e_pkg::PHASE_0;
            leftover_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            leftover_reg <= leftover_next;
        end
    end

    // A final byte closes the group and clears the leftover bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && final_byte |=> phase_reg == b64e_pkg::PHASE_0 && leftover_reg == 4'd0)
        else $error("group state not cleared after final byte");

endmodule

>>> sv/b64e_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder request queue
// Short FIFO of byte requests between the front end and the back end.
// ----------------------------------------------------------------------------
module b64e_queue
#(
    parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  b64e_pkg::b64e_req_t   push_req,
    input  logic                  pop,
    output b64e_pkg::b64e_req_t   head,
    output b64e_pkg::b64e_qstat_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    b64e_pkg::b64e_req_t entries_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign head        = entries_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == CNT_FULL);
    assign qstat.empty = (count_reg == '0);

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_req;
    end

    // The front end never writes a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg < CNT_FULL)
        else $error("push into full queue");

    // The back end never reads an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

endmodule

>>> sv/b64e_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Unless stalled, walks the head request one character per cycle to out_char.
// ----------------------------------------------------------------------------
module b64e_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  b64e_pkg::b64e_req_t   head,
    input  b64e_pkg::b64e_qstat_t qstat,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_char,
    output logic                  final_char
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg;
    logic       final_char_reg;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       have_req;
    logic       req_done;

    // The output register takes a new character when empty or being drained.
    assign load     = !out_valid_reg || out_ready;
    assign have_req = !qstat.empty;
    assign req_done = (idx_reg == head.last_idx);
    assign pop      = load && have_req && req_done;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next = have_req;
            if (have_req)
                idx_next = req_done ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Character payload.
    always_ff @(posedge clk)
    begin
        if (load && have_req)
        begin
            out_char_reg   <= head.chars[idx_reg];
            final_char_reg <= head.final_req && req_done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign final_char = final_char_reg;

    // The character index stays inside the head request.
    assert property (@(posedge clk) disable iff (!rst_n)
        have_req |-> idx_reg <= head.last_idx)
        else $error("character index past end of request");

    // Finishing a request starts the next one at its first character.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> idx_reg == 2'd0)
        else $error("character index not rewound after request");

endmodule

>>> sv/base64_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder
// Streaming Base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// Usage:
//   The slave side takes one message byte per request in s_axis_tdata, with
//   s_axis_tlast high on the last byte of the message. The master side gives
//   one ASCII character per request in m_axis_tdata; m_axis_tlast marks the
//   last character of the encoded message. No line breaks are inserted.
//   A byte causes one or two characters, and a last byte up to four with
//   the padding. The first character of a byte passes through the request
//   queue into the output register, behind any earlier requests.
//   Throughput is one character per cycle while requests wait and the
//   receiver is ready, set by the single output register; bytes are taken
//   at up to one per cycle while the request queue (QUEUE_DEPTH entries)
//   has room.
//   When the receiver stalls, the output register holds its character, the
//   queue fills and s_axis_tready drops until room opens again.
//   Reset clears the group phase, the leftover bits, the queue and the
//   output register; the block is ready for a new message right after it.
// ----------------------------------------------------------------------------
module base64_encoder
#(
    parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // final_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast    // final_char
);

    b64e_pkg::b64e_req_t   push_req;
    b64e_pkg::b64e_req_t   head;
    b64e_pkg::b64e_qstat_t qstat;
    logic                  push;
    logic                  pop;

    // Byte intake and classification.
    b64e_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .data_byte  (s_axis_tdata),
        .final_byte (s_axis_tlast),
        .qstat      (qstat),
        .push       (push),
        .req        (push_req)
    );

    // Request queue between the two ends.
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    // Character emission.
    b64e_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_char   (m_axis_tdata),
        .final_char (m_axis_tlast)
    );

endmodule

>>> tb/base64_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder testbench
// Feeds message bytes through the slave stream and checks every character on
// the master stream against typed table rows or a behavioral encoder in this
// bench. A short table of known groups runs first, then random messages under
// four idle/stall mixes, one of them with a long receiver hold-off.
// ----------------------------------------------------------------------------
module base64_encoder_tb;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 11;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_CYCLES     = 80;
    localparam int BYTES_PER_PHASE = 50;
    localparam int NUM_PHASES      = 4;

    // One encoded character as it should leave the block.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } enc_char_t;

    // One row of the directed table; n_typed of zero means use the predictor.
    typedef struct {
        logic [7:0]                          data;
        logic                                fin;
        int                                  n_typed;
        logic [b64e_pkg::MAX_CHARS-1:0][7:0] typed;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    // Encoder state mirrored by the predictor.
    b64e_pkg::phase_t group_phase;
    logic [3:0]       carry_bits;

    enc_char_t  expected_chars[$];
    stim_row_t  dir_rows[$];

    int   error_count;
    int   bytes_sent;
    int   messages_sent;
    int   chars_checked;
    int   send_idle_pct;
    int   stall_pct;
    logic rx_hold;

    base64_encoder u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hard limit on the run time, well beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Alphabet lookup for one 6-bit symbol.
    function automatic logic [7:0] symbol_char(input logic [5:0] s);
        if (s < 6'd26)
            return b64e_pkg::CHAR_UPPER_A + {2'b00, s};
        else if (s < 6'd52)
            return b64e_pkg::CHAR_LOWER_A + {2'b00, s - 6'd26};
        else if (s < 6'd62)
            return b64e_pkg::CHAR_DIGIT_0 + {2'b00, s - 6'd52};
        else if (s == 6'd62)
            return b64e_pkg::CHAR_PLUS;
        else
            return b64e_pkg::CHAR_SLASH;
    endfunction

    // Characters caused by one byte, updating the mirrored group state.
    task automatic encode_byte(input logic [7:0] b, input logic fin,
                               output logic [b64e_pkg::MAX_CHARS-1:0][7:0] chars,
                               output int n);
        chars = '0;
        case (group_phase)
            b64e_pkg::PHASE_1:
            begin
                chars[0]    = symbol_char({carry_bits[1:0], b[7:4]});
                n           = 1;
                group_phase = b64e_pkg::PHASE_2;
                carry_bits  = b[3:0];
            end
            b64e_pkg::PHASE_2:
            begin
                chars[0]    = symbol_char({carry_bits, b[7:6]});
                chars[1]    = symbol_char(b[5:0]);
                n           = 2;
                group_phase = b64e_pkg::PHASE_0;
                carry_bits  = 4'd0;
            end
            default:
            begin
                chars[0]    = symbol_char(b[7:2]);
                n           = 1;
                group_phase = b64e_pkg::PHASE_1;
                carry_bits  = {2'b00, b[1:0]};
            end
        endcase

        // End of message: flush the leftover bits and pad the group.
        if (fin)
        begin
            if (group_phase == b64e_pkg::PHASE_1)
            begin
                chars[n]     = symbol_char({carry_bits[1:0], 4'b0000});
                chars[n + 1] = b64e_pkg::CHAR_PAD;
                chars[n + 2] = b64e_pkg::CHAR_PAD;
                n            = n + 3;
            end
            else if (group_phase == b64e_pkg::PHASE_2)
            begin
                chars[n]     = symbol_char({carry_bits, 2'b00});
                chars[n + 1] = b64e_pkg::CHAR_PAD;
                n            = n + 2;
            end
            group_phase = b64e_pkg::PHASE_0;
            carry_bits  = 4'd0;
        end
    endtask

    function automatic stim_row_t stim_row(input logic [7:0] data, input logic fin,
                                           input string typed);
        stim_row_t r;
        r.data    = data;
        r.fin     = fin;
        r.n_typed = typed.len();
        r.typed   = '0;
        for (int i = 0; i < typed.len(); i++)
            r.typed[i] = typed[i];
        return r;
    endfunction

    // Offer one byte after a random idle gap and log what it should produce.
    task automatic send_byte(input logic [7:0] b, input logic fin, input int n_typed,
                             input logic [b64e_pkg::MAX_CHARS-1:0][7:0] typed);
        logic [b64e_pkg::MAX_CHARS-1:0][7:0] chars;
        int                                  n;
        enc_char_t                           c;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge clk); while (!s_axis_tready);

        encode_byte(b, fin, chars, n);
        if (n_typed > 0)
        begin
            chars = typed;
            n     = n_typed;
        end
        for (int i = 0; i < n; i++)
        begin
            c.ch   = chars[i];
            c.last = fin && (i == n - 1);
            expected_chars.push_back(c);
        end
        bytes_sent++;
        if (fin)
            messages_sent++;
    endtask

    // Random message with a few forced extreme bytes.
    task automatic send_message(input int len);
        logic [7:0] b;
        int         r;
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(9);
            if (r == 0)
                b = 8'h00;
            else if (r == 1)
                b = 8'hFF;
            else
                b = 8'($urandom_range(255));
            send_byte(b, i == len - 1, 0, '0);
        end
    endtask

    task automatic check_char(input logic [7:0] ch, input logic last);
        enc_char_t exp_c;
        if (expected_chars.size() == 0)
        begin
            report_mismatch($sformatf("unexpected char 0x%02h last=%0b", ch, last));
            return;
        end
        exp_c = expected_chars.pop_front();
        chars_checked++;
        if (ch !== exp_c.ch)
            report_mismatch($sformatf("char 0x%02h, wanted 0x%02h", ch, exp_c.ch));
        if (last !== exp_c.last)
            report_mismatch($sformatf("tlast %0b on char 0x%02h, wanted %0b",
                                      last, ch, exp_c.last));
    endtask

    // Receiver: check each accepted character, then pick the next ready.
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                check_char(m_axis_tdata, m_axis_tlast);
            if (rx_hold)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial
    begin
        int target;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        rst_n         <= 1'b0;
        rx_hold       <= 1'b0;
        group_phase   = b64e_pkg::PHASE_0;
        carry_bits    = 4'd0;
        error_count   = 0;
        bytes_sent    = 0;
        messages_sent = 0;
        chars_checked = 0;
        send_idle_pct = 0;
        stall_pct     = 0;

        // Known groups first, including single-byte messages and padding.
        dir_rows.push_back(stim_row(8'h00, 1'b1, "AA=="));
        dir_rows.push_back(stim_row(8'hFF, 1'b1, "/w=="));
        dir_rows.push_back(stim_row(8'h4D, 1'b0, "T"));
        dir_rows.push_back(stim_row(8'h61, 1'b0, "W"));
        dir_rows.push_back(stim_row(8'h6E, 1'b1, "Fu"));
        dir_rows.push_back(stim_row(8'h4D, 1'b0, "T"));
        dir_rows.push_back(stim_row(8'h61, 1'b1, "WE="));
        dir_rows.push_back(stim_row(8'hFF, 1'b0, "/"));
        dir_rows.push_back(stim_row(8'hFF, 1'b0, "/"));
        dir_rows.push_back(stim_row(8'hFF, 1'b1, "//"));
        dir_rows.push_back(stim_row(8'h00, 1'b0, "A"));
        dir_rows.push_back(stim_row(8'h00, 1'b0, "A"));
        dir_rows.push_back(stim_row(8'h00, 1'b1, "AA"));
        dir_rows.push_back(stim_row(8'hFB, 1'b0, "+"));
        dir_rows.push_back(stim_row(8'hEF, 1'b0, "+"));
        dir_rows.push_back(stim_row(8'hBE, 1'b1, "++"));
        dir_rows.push_back(stim_row(8'h55, 1'b0, ""));
        dir_rows.push_back(stim_row(8'hAA, 1'b1, ""));
        dir_rows.push_back(stim_row(8'h7F, 1'b0, ""));
        dir_rows.push_back(stim_row(8'h80, 1'b0, ""));
        dir_rows.push_back(stim_row(8'h01, 1'b0, ""));
        dir_rows.push_back(stim_row(8'hFE, 1'b1, ""));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].data, dir_rows[i].fin, dir_rows[i].n_typed,
                      dir_rows[i].typed);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 73;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 73;
                end
                default:
                begin
                    send_idle_pct = 15;
                    stall_pct     = 15;
                end
            endcase

            // Long receiver hold-off while bytes keep coming, to fill the queue.
            if (p == 0)
            begin
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        rx_hold <= 1'b0;
                    end
                join_none
            end

            target = bytes_sent + BYTES_PER_PHASE;
            while (bytes_sent < target)
                send_message(($urandom_range(4) == 0) ? 1 : $urandom_range(1, 8));
        end
        s_axis_tvalid <= 1'b0;

        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Encoded %0d messages (%0d bytes), checked %0d characters.",
                 messages_sent, bytes_sent, chars_checked);
        $display("Covered all pad lengths, alphabet extremes, idle/stall mixes and a hold-off.");
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
sv/b64e_pkg.sv
sv/b64e_front.sv
sv/b64e_queue.sv
sv/b64e_back.sv
sv/base64_encoder.sv
tb/base64_encoder_tb.sv
